// ===== rtl/trcpu_pkg.sv =====
package trcpu_pkg;

   // Word and address sizes of the machine.
   localparam int WORD_W = 16;
   localparam int ADDR_W = 15;

   // Default store depths in words.
   localparam int PROG_DEPTH_DEF = 32768;
   localparam int DATA_DEPTH_DEF = 32768;

   // Instruction bit positions for compute instructions.
   localparam int BIT_CINST = 15;
   localparam int BIT_MSEL  = 12;
   localparam int BIT_ZX    = 11;
   localparam int BIT_NX    = 10;
   localparam int BIT_ZY    = 9;
   localparam int BIT_NY    = 8;
   localparam int BIT_ADD   = 7;
   localparam int BIT_NO    = 6;
   localparam int BIT_DEST_A = 5;
   localparam int BIT_DEST_D = 4;
   localparam int BIT_DEST_M = 3;
   localparam int BIT_JLT   = 2;
   localparam int BIT_JEQ   = 1;
   localparam int BIT_JGT   = 0;

   // Commands carried on the request channel.
   typedef enum logic [1:0] {
      CMD_STEP       = 2'd0,
      CMD_LOAD_PROG  = 2'd1,
      CMD_WRITE_DATA = 2'd2,
      CMD_READ_DATA  = 2'd3
   } cmd_type;

   // Status returned by the ALU.
   typedef struct packed {
      logic [WORD_W-1:0] result;
      logic              jump;
   } alu_out_type;

endpackage

// ===== rtl/trcpu_ram.sv =====
module trcpu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write and one registered read per cycle; read data holds when idle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/trcpu_alu.sv =====
module trcpu_alu (
   input  logic [trcpu_pkg::WORD_W-1:0] instr,
   input  logic [trcpu_pkg::WORD_W-1:0] x,
   input  logic [trcpu_pkg::WORD_W-1:0] y,
   output trcpu_pkg::alu_out_type       alu_out
);

   logic [trcpu_pkg::WORD_W-1:0] xz, xn, yz, yn, fr, res;

   // Operand conditioning, function select and output inversion.
   always_comb begin
      xz  = instr[trcpu_pkg::BIT_ZX] ? '0 : x;
      xn  = instr[trcpu_pkg::BIT_NX] ? ~xz : xz;
      yz  = instr[trcpu_pkg::BIT_ZY] ? '0 : y;
      yn  = instr[trcpu_pkg::BIT_NY] ? ~yz : yz;
      fr  = instr[trcpu_pkg::BIT_ADD] ? (xn + yn) : (xn & yn);
      res = instr[trcpu_pkg::BIT_NO] ? ~fr : fr;
   end

   // The jump condition looks at the sign and zero of the result.
   always_comb begin
      alu_out.result = res;
      if (res[trcpu_pkg::WORD_W-1]) begin
         alu_out.jump = instr[trcpu_pkg::BIT_JLT];
      end else if (res == '0) begin
         alu_out.jump = instr[trcpu_pkg::BIT_JEQ];
      end else begin
         alu_out.jump = instr[trcpu_pkg::BIT_JGT];
      end
   end

endmodule

// ===== rtl/two_register_cpu_core.sv =====
// A request's response is loaded as it leaves S_WAIT, or S_OPER for a compute instruction
// that takes its operand from the data store; a stalled response output holds it back.
// A new request is taken only in S_IDLE, once the last one has finished: the synchronous
// program-store fetch, then for a memory operand the data-store operand read.
// Reset: synchronous, clears the registers, then sweeps all DATA_DEPTH words of the data
// store to zero one word per cycle while req_tready stays low; the program store is kept.
module two_register_cpu_core #(
   parameter int PROG_DEPTH = trcpu_pkg::PROG_DEPTH_DEF,
   parameter int DATA_DEPTH = trcpu_pkg::DATA_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // address [14:0], data [30:15], zero [31]
   input  logic [31:0] req_tdata,
   // command [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data [15:0], pc_after [31:16], addr_reg_after [47:32],
   // data_reg_after [63:48], mem_written [64], mem_write_address [79:65]
   output logic [79:0] rsp_tdata
);

   localparam int WW      = trcpu_pkg::WORD_W;
   localparam int AW      = trcpu_pkg::ADDR_W;
   localparam int PROG_AW = $clog2(PROG_DEPTH);
   localparam int DATA_AW = $clog2(DATA_DEPTH);
   localparam logic [AW:0] PROG_LIMIT = (AW + 1)'(PROG_DEPTH);
   localparam logic [AW:0] DATA_LIMIT = (AW + 1)'(DATA_DEPTH);
   localparam logic [DATA_AW-1:0] CLEAR_LAST = DATA_AW'(DATA_DEPTH - 1);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_WAIT  = 4'b0100,
      S_OPER  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [DATA_AW-1:0] clear_ff, clear_in;
   logic [WW-1:0]      pc_ff, pc_in;
   logic [WW-1:0]      a_ff, a_in;
   logic [WW-1:0]      d_ff, d_in;
   trcpu_pkg::cmd_type cmd_ff, cmd_in;
   logic               prog_ok_ff, prog_ok_in;
   logic               data_ok_ff, data_ok_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [79:0]        rsp_data_ff, rsp_data_in;

   // Request fields.
   trcpu_pkg::cmd_type req_cmd;
   logic [AW-1:0]      req_addr;
   logic [WW-1:0]      req_data;
   logic               req_xfer;
   logic               out_free;

   // Memory ports.
   logic               prog_we, prog_re;
   logic [PROG_AW-1:0] prog_wa, prog_ra;
   logic [WW-1:0]      prog_rd;
   logic               data_we, data_re;
   logic [DATA_AW-1:0] data_wa, data_ra;
   logic [WW-1:0]      data_wd, data_rd;

   // Datapath.
   logic [WW-1:0]          instr, y_opnd, read_word;
   trcpu_pkg::alu_out_type alu_out;
   logic                   finish, mem_wr;
   logic [AW-1:0]          mem_wr_addr;

   assign req_cmd  = trcpu_pkg::cmd_type'(req_tuser);
   assign req_addr = req_tdata[AW-1:0];
   assign req_data = req_tdata[AW+WW-1:AW];
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The fetched word reads as zero when the fetch address lies beyond the store.
   assign instr  = prog_ok_ff ? prog_rd : '0;
   assign y_opnd = (state_ff == S_OPER) ? (data_ok_ff ? data_rd : '0) : a_ff;
   assign read_word = data_ok_ff ? data_rd : '0;

   trcpu_ram #(.WIDTH(WW), .DEPTH(PROG_DEPTH)) u_prog_ram (
      .clock   (clock),
      .wr_en   (prog_we),
      .wr_addr (prog_wa),
      .wr_data (req_data),
      .rd_en   (prog_re),
      .rd_addr (prog_ra),
      .rd_data (prog_rd)
   );

   trcpu_ram #(.WIDTH(WW), .DEPTH(DATA_DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_wa),
      .wr_data (data_wd),
      .rd_en   (data_re),
      .rd_addr (data_ra),
      .rd_data (data_rd)
   );

   trcpu_alu u_alu (
      .instr   (instr),
      .x       (d_ff),
      .y       (y_opnd),
      .alu_out (alu_out)
   );

   // Sequencer: clear the data store, issue the memory accesses, then finish the request.
   always_comb begin
      state_in    = state_ff;
      clear_in    = clear_ff;
      pc_in       = pc_ff;
      a_in        = a_ff;
      d_in        = d_ff;
      cmd_in      = cmd_ff;
      prog_ok_in  = prog_ok_ff;
      data_ok_in  = data_ok_ff;
      prog_we     = 1'b0;
      prog_wa     = req_addr[PROG_AW-1:0];
      prog_re     = 1'b0;
      prog_ra     = pc_ff[PROG_AW-1:0];
      data_we     = 1'b0;
      data_wa     = req_addr[DATA_AW-1:0];
      data_wd     = req_data;
      data_re     = 1'b0;
      data_ra     = req_addr[DATA_AW-1:0];
      finish      = 1'b0;
      mem_wr      = 1'b0;
      mem_wr_addr = '0;
      case (state_ff)
         S_CLEAR: begin
            data_we  = 1'b1;
            data_wa  = clear_ff;
            data_wd  = '0;
            clear_in = clear_ff + 1'b1;
            if (clear_ff == CLEAR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in   = req_cmd;
               state_in = S_WAIT;
               case (req_cmd)
                  trcpu_pkg::CMD_STEP: begin
                     prog_re    = 1'b1;
                     prog_ok_in = ({1'b0, pc_ff[AW-1:0]} < PROG_LIMIT);
                  end
                  trcpu_pkg::CMD_LOAD_PROG: begin
                     prog_we = ({1'b0, req_addr} < PROG_LIMIT);
                  end
                  trcpu_pkg::CMD_WRITE_DATA: begin
                     data_we = ({1'b0, req_addr} < DATA_LIMIT);
                  end
                  trcpu_pkg::CMD_READ_DATA: begin
                     data_re    = 1'b1;
                     data_ok_in = ({1'b0, req_addr} < DATA_LIMIT);
                  end
                  default: begin
                     state_in = S_WAIT;
                  end
               endcase
            end
         end
         S_WAIT: begin
            if (cmd_ff == trcpu_pkg::CMD_STEP && instr[trcpu_pkg::BIT_CINST] &&
                instr[trcpu_pkg::BIT_MSEL]) begin
               // Memory operand: read the word at the address register first.
               data_re    = 1'b1;
               data_ra    = a_ff[DATA_AW-1:0];
               data_ok_in = ({1'b0, a_ff[AW-1:0]} < DATA_LIMIT);
               state_in   = S_OPER;
            end else if (out_free) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_OPER: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Retire a step: update the registers and store the result where asked.
      if (finish && cmd_ff == trcpu_pkg::CMD_STEP) begin
         pc_in = pc_ff + 1'b1;
         if (!instr[trcpu_pkg::BIT_CINST]) begin
            a_in = {1'b0, instr[AW-1:0]};
         end else begin
            if (alu_out.jump) begin
               pc_in = a_ff;
            end
            if (instr[trcpu_pkg::BIT_DEST_M]) begin
               data_we     = ({1'b0, a_ff[AW-1:0]} < DATA_LIMIT);
               data_wa     = a_ff[DATA_AW-1:0];
               data_wd     = alu_out.result;
               mem_wr      = 1'b1;
               mem_wr_addr = a_ff[AW-1:0];
            end
            if (instr[trcpu_pkg::BIT_DEST_D]) begin
               d_in = alu_out.result;
            end
            if (instr[trcpu_pkg::BIT_DEST_A]) begin
               a_in = alu_out.result;
            end
         end
      end
   end

   // Response register: loaded when a request finishes; its valid flag is cleared after its transfer.
   always_comb begin
      rsp_data_in   = rsp_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      if (finish) begin
         rsp_data_in = {mem_wr_addr, mem_wr, d_in, a_in, pc_in,
                        (cmd_ff == trcpu_pkg::CMD_READ_DATA) ? read_word : {WW{1'b0}}};
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_ff      <= '0;
         pc_ff         <= '0;
         a_ff          <= '0;
         d_ff          <= '0;
         cmd_ff        <= trcpu_pkg::CMD_STEP;
         prog_ok_ff    <= 1'b0;
         data_ok_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_ff      <= clear_in;
         pc_ff         <= pc_in;
         a_ff          <= a_in;
         d_ff          <= d_in;
         cmd_ff        <= cmd_in;
         prog_ok_ff    <= prog_ok_in;
         data_ok_ff    <= data_ok_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== tb/tb_two_register_cpu_core.sv =====
module tb_two_register_cpu_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WW = trcpu_pkg::WORD_W;
   localparam int AW = trcpu_pkg::ADDR_W;

   // Fields of one response transfer, read_data in the lowest bits.
   typedef struct packed {
      logic [AW-1:0] mem_write_address;
      logic          mem_written;
      logic [WW-1:0] data_reg_after;
      logic [WW-1:0] addr_reg_after;
      logic [WW-1:0] pc_after;
      logic [WW-1:0] read_data;
   } core_status_type;

   // Shadow copy of the machine: it executes every accepted request and keeps the
   // machine status that each response must carry, oldest first.
   class core_shadow_type;
      bit [WW-1:0]     prog_mem [trcpu_pkg::PROG_DEPTH_DEF];
      bit              prog_known [trcpu_pkg::PROG_DEPTH_DEF];
      bit [WW-1:0]     data_mem [trcpu_pkg::DATA_DEPTH_DEF];
      bit [WW-1:0]     areg;
      bit [WW-1:0]     dreg;
      bit [WW-1:0]     pc;
      core_status_type due_states[$];
      int errors;
      int steps, computes, jumps, stores, loads, writes, reads;

      function void note_request(trcpu_pkg::cmd_type cmd, logic [AW-1:0] adr,
                                 logic [WW-1:0] dat);
         core_status_type s;
         bit [WW-1:0]     op, old_a, x, y, r;
         bit              jump;
         s = '0;
         case (cmd)
            trcpu_pkg::CMD_STEP: begin
               steps++;
               op = prog_mem[pc[AW-1:0]];
               old_a = areg;
               pc = pc + 1'b1;
               if (!op[trcpu_pkg::BIT_CINST]) begin
                  areg = {1'b0, op[AW-1:0]};
               end else begin
                  computes++;
                  x = dreg;
                  y = op[trcpu_pkg::BIT_MSEL] ? data_mem[old_a[AW-1:0]] : old_a;
                  if (op[trcpu_pkg::BIT_ZX]) x = '0;
                  if (op[trcpu_pkg::BIT_NX]) x = ~x;
                  if (op[trcpu_pkg::BIT_ZY]) y = '0;
                  if (op[trcpu_pkg::BIT_NY]) y = ~y;
                  r = op[trcpu_pkg::BIT_ADD] ? x + y : x & y;
                  if (op[trcpu_pkg::BIT_NO]) r = ~r;
                  // The sign and zero of the result pick which jump bit applies.
                  if (r[WW-1]) jump = op[trcpu_pkg::BIT_JLT];
                  else if (r == '0) jump = op[trcpu_pkg::BIT_JEQ];
                  else jump = op[trcpu_pkg::BIT_JGT];
                  // Jump target and store address both use the address register
                  // as it was before this instruction.
                  if (jump) begin
                     pc = old_a;
                     jumps++;
                  end
                  if (op[trcpu_pkg::BIT_DEST_M]) begin
                     data_mem[old_a[AW-1:0]] = r;
                     s.mem_written = 1'b1;
                     s.mem_write_address = old_a[AW-1:0];
                     stores++;
                  end
                  if (op[trcpu_pkg::BIT_DEST_D]) dreg = r;
                  if (op[trcpu_pkg::BIT_DEST_A]) areg = r;
               end
            end
            trcpu_pkg::CMD_LOAD_PROG: begin
               prog_mem[adr] = dat;
               prog_known[adr] = 1'b1;
               loads++;
            end
            trcpu_pkg::CMD_WRITE_DATA: begin
               data_mem[adr] = dat;
               writes++;
            end
            trcpu_pkg::CMD_READ_DATA: begin
               s.read_data = data_mem[adr];
               reads++;
            end
            default: begin
            end
         endcase
         s.pc_after = pc;
         s.addr_reg_after = areg;
         s.data_reg_after = dreg;
         due_states.push_back(s);
      endfunction

      function void compare_field(string name, logic [WW-1:0] want, logic [WW-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
         end
      endfunction

      function void check_response(logic [79:0] raw);
         core_status_type want, got;
         got = raw;
         if (due_states.size() == 0) begin
            errors++;
            $display("%0t: response %h arrived with nothing expected", $realtime, raw);
            return;
         end
         want = due_states.pop_front();
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("pc_after", want.pc_after, got.pc_after);
         compare_field("addr_reg_after", want.addr_reg_after, got.addr_reg_after);
         compare_field("data_reg_after", want.data_reg_after, got.data_reg_after);
         compare_field("mem_written", WW'(want.mem_written), WW'(got.mem_written));
         compare_field("mem_write_address", WW'(want.mem_write_address),
                       WW'(got.mem_write_address));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;

   core_shadow_type board;
   bit              calm;
   int              sent;

   two_register_cpu_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard limit on the run, far beyond the slowest correct run including the
   // data-store clearing pass after reset.
   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Response side: checks every transfer and, outside the calm phase, stalls in random bursts.
   initial begin : sink
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) board.check_response(rsp_tdata);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (!calm && !reset && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 15) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One request transfer, sometimes after a random gap; the shadow executes it
   // as soon as it is accepted.
   task automatic send_item(input trcpu_pkg::cmd_type cmd, input logic [AW-1:0] adr,
                            input logic [WW-1:0] dat);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, dat, adr};
      do @(posedge clock); while (!req_tready);
      board.note_request(cmd, adr, dat);
      sent++;
   endtask

   // Places an instruction at the current fetch address, then executes it.
   task automatic run_instruction(input logic [WW-1:0] instr);
      send_item(trcpu_pkg::CMD_LOAD_PROG, board.pc[AW-1:0], instr);
      send_item(trcpu_pkg::CMD_STEP, AW'($urandom), WW'($urandom));
   endtask

   // Mostly a small window, so that reads and memory operands meet written words.
   function automatic logic [AW-1:0] pick_address();
      if ($urandom_range(0, 9) < 6) return AW'($urandom_range(0, 63));
      return AW'($urandom);
   endfunction

   function automatic logic [WW-1:0] random_instruction();
      logic [WW-1:0] word;
      word = WW'($urandom);
      if ($urandom_range(0, 99) < 45) return {1'b0, pick_address()};
      word[trcpu_pkg::BIT_CINST] = 1'b1;
      return word;
   endfunction

   // Stimulus.
   initial begin : stimulus
      int pick;
      board = new;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = trcpu_pkg::CMD_STEP;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every command, wrap of the fetch address and
      // the use of the old address register for jump and store.
      send_item(trcpu_pkg::CMD_READ_DATA, 15'h0000, 16'hFFFF);
      send_item(trcpu_pkg::CMD_WRITE_DATA, 15'h7FFF, 16'hFFFF);
      send_item(trcpu_pkg::CMD_READ_DATA, 15'h7FFF, 16'h0000);
      send_item(trcpu_pkg::CMD_LOAD_PROG, 15'h7FFF, 16'hFFFF);
      send_item(trcpu_pkg::CMD_WRITE_DATA, 15'h0000, 16'hA5A5);
      run_instruction(16'h7FFF);   // A = 0x7FFF
      run_instruction(16'hFC10);   // D = M
      run_instruction(16'h87EA);   // AM = D+1; JEQ, bits 14 and 13 clear
      send_item(trcpu_pkg::CMD_READ_DATA, 15'h7FFF, 16'h0000);
      run_instruction(16'hEEA0);   // A = -1, fetched from the top word
      run_instruction(16'hEA87);   // 0; JMP, fetch address 0x8000 wraps to word 0
      run_instruction(16'h0000);   // executes at 0xFFFF, counter wraps to zero
      run_instruction(16'hF554);   // D = D|M; JLT

      // Hold off until the machine has answered everything.
      req_tvalid <= 1'b0;
      while (board.due_states.size() != 0) @(posedge clock);

      // Random programs built on the fly: a step always finds its program word
      // written, now and then replaced by a fresh one.
      while (sent < 1570) begin
         calm = (sent >= 1380);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if (!board.prog_known[board.pc[AW-1:0]] || $urandom_range(0, 4) == 0)
               send_item(trcpu_pkg::CMD_LOAD_PROG, board.pc[AW-1:0], random_instruction());
            send_item(trcpu_pkg::CMD_STEP, AW'($urandom), WW'($urandom));
         end else if (pick < 70) begin
            send_item(trcpu_pkg::CMD_WRITE_DATA, pick_address(), WW'($urandom));
         end else if (pick < 85) begin
            send_item(trcpu_pkg::CMD_READ_DATA, pick_address(), WW'($urandom));
         end else begin
            send_item(trcpu_pkg::CMD_LOAD_PROG, pick_address(), random_instruction());
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then keep watching for any response that was not expected.
      while (board.due_states.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Ran %0d requests: %0d instruction steps, %0d of them compute, %0d jumps taken,",
               sent, board.steps, board.computes, board.jumps);
      $display("%0d memory stores, %0d program loads, %0d data writes and %0d data reads.",
               board.stores, board.loads, board.writes, board.reads);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== two_register_cpu_core.f =====
rtl/trcpu_pkg.sv
rtl/trcpu_ram.sv
rtl/trcpu_alu.sv
rtl/two_register_cpu_core.sv
tb/tb_two_register_cpu_core.sv
